// File: rtl/pocs_pkg.sv
// ----------------------------------------------------------------------------
// pocs_pkg: shared types and constants
// Widths, command codes, run length and sequencer states of the proximity
// offset calibration and rescaling block.
// ----------------------------------------------------------------------------
package pocs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 6;
  localparam int DIVD_W   = 2 * SAMPLE_W;
  localparam int MEAN_W   = SAMPLE_W + IDX_W;

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = SAMPLE_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

  localparam logic [IDX_W-1:0]    CALIB_SAMPLES = IDX_W'(20);
  localparam logic [IDX_W-1:0]    FIRST_INDEX   = IDX_W'(2);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 16'hFFFF;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MDIV,
    ST_MEND,
    ST_SETUP,
    ST_SDIV,
    ST_DONE
  } state_t;

endpackage

// File: rtl/pocs_in_if.sv
// ----------------------------------------------------------------------------
// pocs_in_if: request channel
// valid/ready channel carrying one command and its 16-bit value.
// ----------------------------------------------------------------------------
interface pocs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pocs_pkg::CMD_W-1:0]    cmd;
  logic [pocs_pkg::SAMPLE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: rtl/pocs_out_if.sv
// ----------------------------------------------------------------------------
// pocs_out_if: result channel
// valid/ready channel carrying the rescaled sample, offset and run status.
// ----------------------------------------------------------------------------
interface pocs_out_if;
  logic                          valid;
  logic                          ready;
  logic [pocs_pkg::SAMPLE_W-1:0] scaled_proximity;
  logic [pocs_pkg::SAMPLE_W-1:0] current_offset;
  logic                          calibrating;
  logic                          calibration_done;

  modport source (output valid, output scaled_proximity, output current_offset,
                  output calibrating, output calibration_done, input ready);
  modport sink   (input valid, input scaled_proximity, input current_offset,
                  input calibrating, input calibration_done, output ready);
endinterface

// File: rtl/proximity_offset_calibrate_scale.sv
// ----------------------------------------------------------------------------
// proximity_offset_calibrate_scale: offset calibration and full-scale rescale
// Keeps the last proximity sample and an offset, runs a running-mean offset
// calibration and returns the offset-removed sample rescaled to full range.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one request: cmd 0 stores a sample (and folds it into an
//          active calibration run), cmd 1 (re)starts a run seeded with the
//          last sample, cmd 2 loads the offset, cmd 3 only reports.
//   out_ch returns exactly one result per request: the rescaled sample
//          floor((p-o)*65535/(65535-o)) (0 when p <= o), the offset in use,
//          the run flag and a one-shot done flag.
// Sequencing:
//   The rescale runs on the shared radix-4 restoring divider and is
//   skipped when p <= o. A sample taken during a run first uses the same
//   divider for the mean update (ST_MDIV, then ST_MEND retires the mean).
//   A request then passes ST_SETUP, ST_SDIV (skipped with the rescale) and
//   ST_DONE before its result is registered; in_ch.ready is high only
//   while the sequencer is idle, so a new request is taken only once the
//   last one has left ST_DONE.
// Reset: rst (synchronous) clears sample, offset, run state and the output
//   valid flag; the block is ready in the first cycle after reset.
// Stall: a finished result waits in the output register while the next
//   request is already accepted and worked on; the sequencer holds in its
//   final state only if the output register is still full.
// ----------------------------------------------------------------------------
module proximity_offset_calibrate_scale (
  input  logic       clk,
  input  logic       rst,
  pocs_in_if.sink    in_ch,
  pocs_out_if.source out_ch
);

  localparam int SW = pocs_pkg::SAMPLE_W;

  pocs_pkg::state_t state, state_next;

  // architectural state
  logic [SW-1:0]                last_sample;
  logic [SW-1:0]                offset_value;
  logic                         run_active;
  logic [pocs_pkg::IDX_W-1:0]   run_index;
  logic [SW-1:0]                running_mean;

  // per-request bookkeeping
  logic [pocs_pkg::IDX_W-1:0]   fold_index;   // index used by this mean update
  logic                         done_flag;
  logic [SW-1:0]                scaled;

  // shared divider
  logic [SW:0]                  div_rem;
  logic [SW-1:0]                div_quo;
  logic [SW-1:0]                div_low;
  logic [SW-1:0]                div_den;
  logic [pocs_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [SW:0]                  div_rem_next;
  logic [SW-1:0]                div_quo_next;
  logic [SW-1:0]                div_low_next;
  logic                         div_last;

  // output register
  logic                         out_valid;
  logic [SW-1:0]                out_scaled;
  logic [SW-1:0]                out_offset;
  logic                         out_cal;
  logic                         out_done;

  logic                         in_accept;
  logic                         out_free;

  // mean update operands, formed straight from the accepted request
  logic [pocs_pkg::IDX_W-1:0]   idx_sel;
  logic [pocs_pkg::MEAN_W-1:0]  mean_acc;

  // rescale operands
  logic [SW-1:0]                diff;
  logic [pocs_pkg::DIVD_W-1:0]  scale_num;

  assign in_ch.ready = (state == pocs_pkg::ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign div_last    = (div_cnt == pocs_pkg::DIV_CNT_W'(pocs_pkg::DIV_CYCLES - 1));

  assign idx_sel  = (run_index < pocs_pkg::FIRST_INDEX) ? pocs_pkg::FIRST_INDEX : run_index;
  // (i-1)*mean + p, always below i*65536 so the quotient fits 16 bits
  assign mean_acc = pocs_pkg::MEAN_W'(idx_sel - 1'b1) * pocs_pkg::MEAN_W'(running_mean)
                  + pocs_pkg::MEAN_W'(in_ch.value);

  // (p-o)*65535 as (p-o)*65536 - (p-o)
  assign diff      = last_sample - offset_value;
  assign scale_num = {diff, {SW{1'b0}}} - pocs_pkg::DIVD_W'(diff);

  // two restoring division steps per cycle
  always_comb begin
    logic [SW:0] trial;
    div_rem_next = div_rem;
    div_quo_next = div_quo;
    div_low_next = div_low;
    for (int k = 0; k < pocs_pkg::DIV_BITS_PER_CYC; k++) begin
      trial        = {div_rem_next[SW-1:0], div_low_next[SW-1]};
      div_low_next = {div_low_next[SW-2:0], 1'b0};
      if (trial >= {1'b0, div_den}) begin
        div_rem_next = trial - {1'b0, div_den};
        div_quo_next = {div_quo_next[SW-2:0], 1'b1};
      end else begin
        div_rem_next = trial;
        div_quo_next = {div_quo_next[SW-2:0], 1'b0};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pocs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pocs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.cmd == pocs_pkg::CMD_SAMPLE && run_active) begin
            state_next = pocs_pkg::ST_MDIV;
          end else begin
            state_next = pocs_pkg::ST_SETUP;
          end
        end
      end
      pocs_pkg::ST_MDIV: begin
        if (div_last) begin
          state_next = pocs_pkg::ST_MEND;
        end
      end
      pocs_pkg::ST_MEND:  state_next = pocs_pkg::ST_SETUP;
      pocs_pkg::ST_SETUP: begin
        if (last_sample <= offset_value) begin
          state_next = pocs_pkg::ST_DONE;
        end else begin
          state_next = pocs_pkg::ST_SDIV;
        end
      end
      pocs_pkg::ST_SDIV: begin
        if (div_last) begin
          state_next = pocs_pkg::ST_DONE;
        end
      end
      pocs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pocs_pkg::ST_IDLE;
        end
      end
      default: state_next = pocs_pkg::ST_IDLE;
    endcase
  end

  // architectural state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample  <= '0;
      offset_value <= '0;
      run_active   <= 1'b0;
      run_index    <= '0;
      running_mean <= '0;
      done_flag    <= 1'b0;
    end else begin
      case (state)
        pocs_pkg::ST_IDLE: begin
          if (in_accept) begin
            done_flag <= 1'b0;
            case (in_ch.cmd)
              pocs_pkg::CMD_SAMPLE: begin
                last_sample <= in_ch.value;
              end
              pocs_pkg::CMD_START: begin
                run_active   <= 1'b1;
                running_mean <= last_sample;
                run_index    <= pocs_pkg::FIRST_INDEX;
              end
              pocs_pkg::CMD_OFFSET: begin
                offset_value <= in_ch.value;
              end
              default: ;
            endcase
          end
        end
        pocs_pkg::ST_MEND: begin
          running_mean <= div_quo;
          if (fold_index >= pocs_pkg::CALIB_SAMPLES) begin
            offset_value <= div_quo;
            run_active   <= 1'b0;
            run_index    <= '0;
            done_flag    <= 1'b1;
          end else begin
            run_index <= fold_index + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // divider loading and stepping; payload registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      pocs_pkg::ST_IDLE: begin
        fold_index <= idx_sel;
        div_cnt    <= '0;
        div_quo    <= '0;
        div_rem    <= (SW+1)'(mean_acc[pocs_pkg::MEAN_W-1:SW]);
        div_low    <= mean_acc[SW-1:0];
        div_den    <= SW'(idx_sel);
      end
      pocs_pkg::ST_SETUP: begin
        div_cnt <= '0;
        div_quo <= '0;
        div_rem <= {1'b0, scale_num[pocs_pkg::DIVD_W-1:SW]};
        div_low <= scale_num[SW-1:0];
        div_den <= pocs_pkg::FULL_SCALE - offset_value;
        scaled  <= '0;
      end
      pocs_pkg::ST_MDIV, pocs_pkg::ST_SDIV: begin
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
        div_low <= div_low_next;
        div_cnt <= div_cnt + 1'b1;
        if (state == pocs_pkg::ST_SDIV && div_last) begin
          scaled <= div_quo_next;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pocs_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pocs_pkg::ST_DONE && out_free) begin
      out_scaled <= scaled;
      out_offset <= offset_value;
      out_cal    <= run_active;
      out_done   <= done_flag;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.scaled_proximity = out_scaled;
  assign out_ch.current_offset   = out_offset;
  assign out_ch.calibrating      = out_cal;
  assign out_ch.calibration_done = out_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_run_index_range: assert property (@(posedge clk) disable iff (rst)
    run_active |-> (run_index >= pocs_pkg::FIRST_INDEX &&
                    run_index <= pocs_pkg::CALIB_SAMPLES))
    else $error("run index out of range during a calibration run");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pocs_pkg::ST_MDIV || state == pocs_pkg::ST_SDIV) |->
      (div_rem < {1'b0, div_den}))
    else $error("divider remainder not below divisor");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> !out_cal)
    else $error("calibration done reported with run still active");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ch.ready)
    else $error("ready raised in the cycle after a request was taken");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: proximity offset calibration and rescale testbench
// Drives sample, start, offset-load and unused requests into the block, keeps
// a cycle-free model of the calibration run and the full-scale rescale, and
// compares each result with it or a typed row's result. A directed table
// comes first, then random traffic, mostly calibration runs, under three idle patterns.
// ----------------------------------------------------------------------------
module tb;

  // cmd 3 has no package name; the block only reports on it
  localparam logic [pocs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int N_DIRECTED   = 25;
  localparam int N_PER_PHASE  = 220;
  localparam int DRAIN_CYCLES = 40;   // outlasts the slowest request (a sample during a run)
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [pocs_pkg::SAMPLE_W-1:0] scaled;
    logic [pocs_pkg::SAMPLE_W-1:0] offset;
    logic                          cal;
    logic                          done;
  } prox_resp_t;

  // typed = 1: resp holds the expected result, read straight off the spec
  // typed = 0: the model supplies the expected result
  typedef struct packed {
    logic [pocs_pkg::CMD_W-1:0]    cmd;
    logic [pocs_pkg::SAMPLE_W-1:0] value;
    logic                          typed;
    prox_resp_t                    resp;
  } dir_row_t;

  // Directed table. One run is started before any sample, disturbed by offset
  // loads at both extremes, restarted, then carried through to completion.
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    // start before any sample: seed is the reset sample of zero
    '{pocs_pkg::CMD_START,  16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b0}},
    // unused command: nothing moves
    '{CMD_UNUSED,           16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b0}},
    '{pocs_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, '0},
    // offset at full scale during a run: sample never above it
    '{pocs_pkg::CMD_OFFSET, 16'hFFFF, 1'b1, '{16'h0000, 16'hFFFF, 1'b1, 1'b0}},
    // zero offset: top sample maps to top of range
    '{pocs_pkg::CMD_OFFSET, 16'h0000, 1'b1, '{16'hFFFF, 16'h0000, 1'b1, 1'b0}},
    // restart mid-run, value ignored
    '{pocs_pkg::CMD_START,  16'h1234, 1'b0, '0},
    // full run from the restart: indices 2..20, the last one ends it
    '{pocs_pkg::CMD_SAMPLE, 16'h0000, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h8000, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h7FFF, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h0001, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hFFFE, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h5555, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hAAAA, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h0000, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h1234, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hEDCB, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h00FF, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hFF00, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h0F0F, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hF0F0, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h3C3C, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'hC3C3, 1'b0, '0},
    '{pocs_pkg::CMD_SAMPLE, 16'h8001, 1'b0, '0}
  };

  logic clk;
  logic rst;

  pocs_in_if  in_ch ();
  pocs_out_if out_ch ();

  proximity_offset_calibrate_scale u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state: mirrors the block after every accepted request.
  logic [pocs_pkg::SAMPLE_W-1:0] cal_sample;
  logic [pocs_pkg::SAMPLE_W-1:0] cal_offset;
  logic                          cal_active;
  logic [pocs_pkg::IDX_W-1:0]    cal_index;
  logic [pocs_pkg::SAMPLE_W-1:0] cal_mean;

  prox_resp_t pending_resp [$];

  int src_idle_pct;
  int snk_idle_pct;
  int n_sent;
  int n_results;
  int n_errors;
  int n_runs_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one request to the model and returns the result the block owes.
  function automatic prox_resp_t scale_and_calibrate(
    input logic [pocs_pkg::CMD_W-1:0]    c,
    input logic [pocs_pkg::SAMPLE_W-1:0] v
  );
    logic [31:0] idx;
    logic [31:0] acc;
    logic        done;
    prox_resp_t  r;
    done = 1'b0;
    case (c)
      pocs_pkg::CMD_SAMPLE: begin
        cal_sample = v;
        if (cal_active) begin
          // running mean: floor(((i-1)*mean + p) / i)
          idx  = (cal_index < pocs_pkg::FIRST_INDEX) ? 32'(pocs_pkg::FIRST_INDEX)
                                                     : 32'(cal_index);
          acc  = (idx - 32'd1) * 32'(cal_mean) + 32'(v);
          cal_mean = pocs_pkg::SAMPLE_W'(acc / idx);
          if (idx >= 32'(pocs_pkg::CALIB_SAMPLES)) begin
            // last index: mean replaces whatever offset was loaded mid-run
            cal_offset = cal_mean;
            cal_active = 1'b0;
            cal_index  = '0;
            done       = 1'b1;
          end else begin
            cal_index = pocs_pkg::IDX_W'(idx + 32'd1);
          end
        end
      end
      pocs_pkg::CMD_START: begin
        cal_active = 1'b1;
        cal_mean   = cal_sample;
        cal_index  = pocs_pkg::FIRST_INDEX;
      end
      pocs_pkg::CMD_OFFSET: cal_offset = v;
      default: ;
    endcase
    // floor((p-o)*FS/(FS-o)); p <= o also keeps the divisor nonzero
    if (cal_sample <= cal_offset)
      r.scaled = '0;
    else
      r.scaled = pocs_pkg::SAMPLE_W'(
                   ((32'(cal_sample) - 32'(cal_offset)) * 32'(pocs_pkg::FULL_SCALE)) /
                   (32'(pocs_pkg::FULL_SCALE) - 32'(cal_offset)));
    r.offset = cal_offset;
    r.cal    = cal_active;
    r.done   = done;
    return r;
  endfunction

  // Sender: optional idle cycles, then hold the request until ready.
  // Each negedge up to the one that raises valid gets exactly one assignment to valid.
  task automatic put_request(input logic [pocs_pkg::CMD_W-1:0]    c,
                             input logic [pocs_pkg::SAMPLE_W-1:0] v,
                             input logic typed, input prox_resp_t typed_resp);
    prox_resp_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = scale_and_calibrate(c, v);
    pending_resp.push_back(typed ? typed_resp : r);
    n_sent++;
  endtask

  // Biased value: extremes and the neighborhood of the offset get extra weight
  // so the p <= o cutoff is hit from both sides.
  function automatic logic [pocs_pkg::SAMPLE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return pocs_pkg::FULL_SCALE;
      2:       return cal_offset + pocs_pkg::SAMPLE_W'($urandom_range(3));
      3:       return cal_offset - pocs_pkg::SAMPLE_W'($urandom_range(3));
      default: return pocs_pkg::SAMPLE_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Random traffic: mostly complete calibration runs, with the odd offset
  // load, restart or unused request thrown in, plus loose samples and noise.
  task automatic run_random(input int n_items);
    int stop;
    int k;
    stop = n_sent + n_items;
    while (n_sent < stop) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          put_request(pocs_pkg::CMD_START, pocs_pkg::SAMPLE_W'($urandom), 1'b0, '0);
          for (k = 1; k < int'(pocs_pkg::CALIB_SAMPLES); k++) begin
            if ($urandom_range(19) == 0) begin
              case ($urandom_range(2))
                0:       put_request(pocs_pkg::CMD_OFFSET, pick_value(), 1'b0, '0);
                1:       put_request(pocs_pkg::CMD_START, pocs_pkg::SAMPLE_W'($urandom),
                                     1'b0, '0);
                default: put_request(CMD_UNUSED, pocs_pkg::SAMPLE_W'($urandom), 1'b0, '0);
              endcase
            end
            put_request(pocs_pkg::CMD_SAMPLE, pick_value(), 1'b0, '0);
          end
        end
        4, 5, 6, 7: begin
          repeat ($urandom_range(1, 6))
            put_request(pocs_pkg::CMD_SAMPLE, pick_value(), 1'b0, '0);
        end
        8:       put_request(pocs_pkg::CMD_OFFSET, pick_value(), 1'b0, '0);
        default: put_request(CMD_UNUSED, pocs_pkg::SAMPLE_W'($urandom), 1'b0, '0);
      endcase
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result checker: oldest expectation against each accepted result.
  always @(posedge clk) begin
    prox_resp_t got;
    prox_resp_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.scaled_proximity, out_ch.current_offset,
              out_ch.calibrating, out_ch.calibration_done};
      n_results++;
      if (got.done === 1'b1)
        n_runs_done++;
      if (pending_resp.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("result %0d with nothing expected: scaled=%h offset=%h cal=%b done=%b",
                   n_results, got.scaled, got.offset, got.cal, got.done);
      end else begin
        want = pending_resp.pop_front();
        if (got.scaled !== want.scaled || got.offset !== want.offset ||
            got.cal !== want.cal || got.done !== want.done) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("result %0d: expected scaled=%h offset=%h cal=%b done=%b,",
                     n_results, want.scaled, want.offset, want.cal, want.done,
                     " got scaled=%h offset=%h cal=%b done=%b",
                     got.scaled, got.offset, got.cal, got.done);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int r;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = pocs_pkg::CMD_SAMPLE;
    in_ch.value  = '0;
    cal_sample   = '0;
    cal_offset   = '0;
    cal_active   = 1'b0;
    cal_index    = '0;
    cal_mean     = '0;
    n_sent       = 0;
    n_results    = 0;
    n_errors     = 0;
    n_runs_done  = 0;
    // phase 1 pattern: rare sender gaps, heavy receiver stalls
    src_idle_pct = 7;
    snk_idle_pct = 73;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_DIRECTED; r++)
      put_request(DIR_ROWS[r].cmd, DIR_ROWS[r].value, DIR_ROWS[r].typed, DIR_ROWS[r].resp);

    run_random(N_PER_PHASE);
    // phase 2: sender mostly idle, receiver nearly always ready
    src_idle_pct = 73;
    snk_idle_pct = 7;
    run_random(N_PER_PHASE);
    // phase 3: back to back
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(N_PER_PHASE);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    // any stray result would show up within this window
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests sent %0d, results checked %0d, calibration runs completed %0d",
             n_sent, n_results, n_runs_done);
    $display("mismatches %0d, expectations left %0d", n_errors, pending_resp.size());
    if (n_errors == 0 && pending_resp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
